// File: src/mfq_pkg.sv
`default_nettype none
package mfq_pkg;

  localparam int LEVELS_DEF    = 3;
  localparam int MAX_TASKS_DEF = 16;

  localparam int FUNC_W    = 3;
  localparam int ID_W      = 4;
  localparam int TICK_W    = 16;
  localparam int LVL_W     = 2;
  localparam int QNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [QNT_W-1:0] QTOP_RST = QNT_W'(2);
  localparam logic [QNT_W-1:0] QMID_RST = QNT_W'(4);
  localparam logic [QNT_W-1:0] QLOW_RST = QNT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_QTOP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QMID = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QLOW = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_READY    = 3'd0,
    FN_PREEMPT  = 3'd1,
    FN_BLOCKED  = 3'd2,
    FN_FINISHED = 3'd3,
    FN_PICK     = 3'd4,
    FN_CHECK    = 3'd5,
    FN_CLEAR    = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PICK
  } st_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } lvl_cmd_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } q_cmd_t;

endpackage
`default_nettype wire

// File: src/mfq_ifs.sv
`default_nettype none
interface mfq_in_if;
  import mfq_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     task_id;
  logic [TICK_W-1:0]   slice_ticks;
  modport source (output valid, output func, output task_id, output slice_ticks, input ready);
  modport sink   (input valid, input func, input task_id, input slice_ticks, output ready);
endinterface

interface mfq_out_if;
  import mfq_pkg::*;
  logic             valid;
  logic             ready;
  logic             picked_valid;
  logic [ID_W-1:0]  picked_task;
  logic             preempt_now;
  logic [LVL_W-1:0] task_level;
  logic             overflow;
  modport source (output valid, output picked_valid, output picked_task, output preempt_now,
                  output task_level, output overflow, input ready);
  modport sink   (input valid, input picked_valid, input picked_task, input preempt_now,
                  input task_level, input overflow, output ready);
endinterface

interface mfq_cfg_if;
  import mfq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [QNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/mfq_lvl_mem.sv
`default_nettype none
module mfq_lvl_mem #(
  parameter int MAX_TASKS = mfq_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mfq_pkg::lvl_cmd_t            cmd,
  input  logic [$clog2(MAX_TASKS)-1:0] rd_idx,
  input  logic [$clog2(MAX_TASKS)-1:0] wr_idx,
  input  logic [mfq_pkg::LVL_W-1:0]    wr_data,
  output logic [mfq_pkg::LVL_W-1:0]    rd_data
);
  import mfq_pkg::*;

  logic [LVL_W-1:0]     mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r;
  logic [LVL_W-1:0]     q_r;
  logic                 q_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      q_r <= mem[rd_idx];
    end
  end

  // entries not written since reset or clear read as level 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_all) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (cmd.rd_en) begin
        q_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule
`default_nettype wire

// File: src/mfq_queue_mem.sv
`default_nettype none
module mfq_queue_mem #(
  parameter int LEVELS    = mfq_pkg::LEVELS_DEF,
  parameter int MAX_TASKS = mfq_pkg::MAX_TASKS_DEF
) (
  input  logic                                clk,
  input  mfq_pkg::q_cmd_t                     cmd,
  input  logic [$clog2(LEVELS*MAX_TASKS)-1:0] rd_addr,
  input  logic [$clog2(LEVELS*MAX_TASKS)-1:0] wr_addr,
  input  logic [mfq_pkg::ID_W-1:0]            wr_data,
  output logic [mfq_pkg::ID_W-1:0]            rd_data
);
  import mfq_pkg::*;

  logic [ID_W-1:0] mem [LEVELS*MAX_TASKS];
  logic [ID_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule
`default_nettype wire

// File: src/mfq_ctrl.sv
`default_nettype none
module mfq_ctrl #(
  parameter int LEVELS    = mfq_pkg::LEVELS_DEF,
  parameter int MAX_TASKS = mfq_pkg::MAX_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mfq_in_if.sink                              in_ch,
  mfq_out_if.source                           out_ch,
  input  logic [mfq_pkg::QNT_W-1:0]           quantum_top,
  input  logic [mfq_pkg::QNT_W-1:0]           quantum_mid,
  input  logic [mfq_pkg::QNT_W-1:0]           quantum_low,
  output mfq_pkg::lvl_cmd_t                   lvl_cmd,
  output logic [$clog2(MAX_TASKS)-1:0]        lvl_rd_idx,
  output logic [$clog2(MAX_TASKS)-1:0]        lvl_wr_idx,
  output logic [mfq_pkg::LVL_W-1:0]           lvl_wr_data,
  input  logic [mfq_pkg::LVL_W-1:0]           lvl_rd_data,
  output mfq_pkg::q_cmd_t                     q_cmd,
  output logic [$clog2(LEVELS*MAX_TASKS)-1:0] q_rd_addr,
  output logic [$clog2(LEVELS*MAX_TASKS)-1:0] q_wr_addr,
  output logic [mfq_pkg::ID_W-1:0]            q_wr_data,
  input  logic [mfq_pkg::ID_W-1:0]            q_rd_data
);
  import mfq_pkg::*;

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int AW  = $clog2(LEVELS*MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS+1);
  localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS-1);

  function automatic logic [IW-1:0] id_idx(input logic [ID_W-1:0] id);
    logic [IW+ID_W-1:0] w;
    w = (IW+ID_W)'(id);
    return w[IW-1:0];
  endfunction

  function automatic logic id_known(input logic [ID_W-1:0] id);
    return int'(id) < MAX_TASKS;
  endfunction

  function automatic logic [AW-1:0] qaddr(input logic [LIW-1:0] lvl, input logic [IW-1:0] slot);
    return AW'(int'(lvl) * MAX_TASKS + int'(slot));
  endfunction

  st_t              state_r, state_nxt;
  func_t            op_r;
  logic [ID_W-1:0]  id_r;
  logic [TICK_W-1:0] ticks_r;
  logic [ID_W-1:0]  pt_r, pt_nxt;
  logic [IW-1:0]    heads_r [LEVELS];
  logic [IW-1:0]    heads_nxt [LEVELS];
  logic [CW-1:0]    counts_r [LEVELS];
  logic [CW-1:0]    counts_nxt [LEVELS];

  logic             out_vld_r;
  logic             pv_r, pv_nxt;
  logic [ID_W-1:0]  ptask_r, ptask_nxt;
  logic             pre_r, pre_nxt;
  logic [LVL_W-1:0] tl_r, tl_nxt;
  logic             ovf_r, ovf_nxt;
  logic             load;

  logic             in_acc, out_free, known, sel_found, enq_full;
  logic [LIW-1:0]   sel_lvl, enq_i;
  logic [LVL_W-1:0] cur_lvl, enq_lvl;
  logic [CW:0]      tail_sum, tail;
  logic [IW-1:0]    head_inc;
  logic [QNT_W-1:0] quantum;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign known    = id_known(id_r);
  assign cur_lvl  = known ? lvl_rd_data : '0;

  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int l = LEVELS-1; l >= 0; l--) begin
      if (counts_r[l] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LIW'(l);
      end
    end
  end

  always_comb begin
    if (op_r == FN_PREEMPT) begin
      enq_lvl = (cur_lvl >= TOP_LVL) ? TOP_LVL : cur_lvl + LVL_W'(1);
    end else begin
      enq_lvl = cur_lvl;
    end
    enq_i    = enq_lvl[LIW-1:0];
    enq_full = counts_r[enq_i] == CW'(MAX_TASKS);
    tail_sum = (CW+1)'(heads_r[enq_i]) + (CW+1)'(counts_r[enq_i]);
    tail     = (tail_sum >= (CW+1)'(MAX_TASKS)) ? tail_sum - (CW+1)'(MAX_TASKS) : tail_sum;
    head_inc = (heads_r[sel_lvl] == IW'(MAX_TASKS-1)) ? '0 : heads_r[sel_lvl] + IW'(1);
    case (cur_lvl)
      2'd0:    quantum = quantum_top;
      2'd1:    quantum = quantum_mid;
      default: quantum = quantum_low;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == FN_PICK && sel_found) begin
          state_nxt = ST_PICK;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_cmd     = '0;
    lvl_rd_idx  = id_idx(in_ch.task_id);
    lvl_wr_idx  = id_idx(id_r);
    lvl_wr_data = enq_lvl;
    q_cmd       = '0;
    q_rd_addr   = qaddr(sel_lvl, heads_r[sel_lvl]);
    q_wr_addr   = qaddr(enq_i, tail[IW-1:0]);
    q_wr_data   = id_r;
    heads_nxt   = heads_r;
    counts_nxt  = counts_r;
    pt_nxt      = pt_r;
    load        = 1'b0;
    pv_nxt      = 1'b0;
    ptask_nxt   = '0;
    pre_nxt     = 1'b0;
    tl_nxt      = '0;
    ovf_nxt     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        lvl_cmd.rd_en = in_acc;
        q_cmd.rd_en   = in_acc;
      end
      ST_EXEC: begin
        if (op_r == FN_PICK && sel_found) begin
          pt_nxt              = q_rd_data;
          lvl_cmd.rd_en       = 1'b1;
          lvl_rd_idx          = id_idx(q_rd_data);
          heads_nxt[sel_lvl]  = head_inc;
          counts_nxt[sel_lvl] = counts_r[sel_lvl] - CW'(1);
        end else if (out_free) begin
          load = 1'b1;
          case (op_r)
            FN_READY, FN_PREEMPT: begin
              if (known) begin
                lvl_cmd.wr_en = 1'b1;
                tl_nxt        = enq_lvl;
                ovf_nxt       = enq_full;
                if (!enq_full) begin
                  q_cmd.wr_en       = 1'b1;
                  counts_nxt[enq_i] = counts_r[enq_i] + CW'(1);
                end
              end
            end
            FN_BLOCKED: begin
              lvl_cmd.wr_en = known;
              lvl_wr_data   = '0;
            end
            FN_FINISHED: begin
              tl_nxt = cur_lvl;
            end
            FN_CHECK: begin
              pre_nxt = ticks_r >= quantum;
              tl_nxt  = cur_lvl;
            end
            FN_CLEAR: begin
              lvl_cmd.clr_all = 1'b1;
              for (int l = 0; l < LEVELS; l++) begin
                heads_nxt[l]  = '0;
                counts_nxt[l] = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PICK: begin
        if (out_free) begin
          load      = 1'b1;
          pv_nxt    = 1'b1;
          ptask_nxt = pt_r;
          tl_nxt    = id_known(pt_r) ? lvl_rd_data : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        heads_r[l]  <= '0;
        counts_r[l] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      heads_r  <= heads_nxt;
      counts_r <= counts_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= func_t'(in_ch.func);
      id_r    <= in_ch.task_id;
      ticks_r <= in_ch.slice_ticks;
    end
    pt_r <= pt_nxt;
    if (load) begin
      pv_r    <= pv_nxt;
      ptask_r <= ptask_nxt;
      pre_r   <= pre_nxt;
      tl_r    <= tl_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign in_ch.ready         = state_r == ST_IDLE;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.picked_valid = pv_r;
  assign out_ch.picked_task  = ptask_r;
  assign out_ch.preempt_now  = pre_r;
  assign out_ch.task_level   = tl_r;
  assign out_ch.overflow     = ovf_r;

endmodule
`default_nettype wire

// File: src/multilevel_feedback_queue_scheduler_top.sv
`default_nettype none
// Multilevel feedback queue scheduler. Each task has a priority level (0 highest) held in
// a level memory, and each level owns a circular FIFO of task ids in a shared queue
// memory. Events: ready (queue at stored level), preempted (demote one level, capped,
// then queue), blocked (level back to 0), finished (no change), pick (pop the oldest id
// from the highest non-empty level), check (slice ticks against the level's quantum) and
// clear (empty all FIFOs, all levels to 0). A push to a full FIFO is dropped and flagged
// as overflow. Every item gives one result. The memories have a registered read: an event
// reads its level and queue head in IDLE and writes back in EXEC once the output is free;
// a pick that finds a task pops it in EXEC, reads its level and gives its result in PICK.
// No clearing pass is needed after reset or clear: the level memory has a valid bit per
// task. The result register lets the next item be taken while the last result waits.
// The user writes quanta through the cfg channel (index 0 top, 1 mid, 2 low) only while
// the block is idle; the block does not enforce this. An unused index is ignored.
module multilevel_feedback_queue_scheduler_top #(
  parameter int LEVELS    = mfq_pkg::LEVELS_DEF,
  parameter int MAX_TASKS = mfq_pkg::MAX_TASKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mfq_in_if.sink    in_ch,
  mfq_out_if.source out_ch,
  mfq_cfg_if.sink   cfg_ch
);
  import mfq_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int AW = $clog2(LEVELS*MAX_TASKS);

  logic [QNT_W-1:0] quantum_top_r;
  logic [QNT_W-1:0] quantum_mid_r;
  logic [QNT_W-1:0] quantum_low_r;

  lvl_cmd_t         lvl_cmd;
  logic [IW-1:0]    lvl_rd_idx, lvl_wr_idx;
  logic [LVL_W-1:0] lvl_wr_data, lvl_rd_data;
  q_cmd_t           q_cmd;
  logic [AW-1:0]    q_rd_addr, q_wr_addr;
  logic [ID_W-1:0]  q_wr_data, q_rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_top_r <= QTOP_RST;
      quantum_mid_r <= QMID_RST;
      quantum_low_r <= QLOW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_QTOP: quantum_top_r <= cfg_ch.data;
        REG_QMID: quantum_mid_r <= cfg_ch.data;
        REG_QLOW: quantum_low_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  mfq_ctrl #(
    .LEVELS    (LEVELS),
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .quantum_top (quantum_top_r),
    .quantum_mid (quantum_mid_r),
    .quantum_low (quantum_low_r),
    .lvl_cmd     (lvl_cmd),
    .lvl_rd_idx  (lvl_rd_idx),
    .lvl_wr_idx  (lvl_wr_idx),
    .lvl_wr_data (lvl_wr_data),
    .lvl_rd_data (lvl_rd_data),
    .q_cmd       (q_cmd),
    .q_rd_addr   (q_rd_addr),
    .q_wr_addr   (q_wr_addr),
    .q_wr_data   (q_wr_data),
    .q_rd_data   (q_rd_data)
  );

  mfq_lvl_mem #(
    .MAX_TASKS (MAX_TASKS)
  ) u_lvl_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (lvl_cmd),
    .rd_idx  (lvl_rd_idx),
    .wr_idx  (lvl_wr_idx),
    .wr_data (lvl_wr_data),
    .rd_data (lvl_rd_data)
  );

  mfq_queue_mem #(
    .LEVELS    (LEVELS),
    .MAX_TASKS (MAX_TASKS)
  ) u_queue_mem (
    .clk     (clk),
    .cmd     (q_cmd),
    .rd_addr (q_rd_addr),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_data (q_rd_data)
  );

`ifndef SYNTHESIS
  a_lvl_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(lvl_cmd.rd_en && (lvl_cmd.wr_en || lvl_cmd.clr_all)))
    else $error("level memory read and write in one cycle");

  a_q_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_cmd.rd_en && q_cmd.wr_en))
    else $error("queue memory read and write in one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item in progress");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.task_level <= LVL_W'(LEVELS-1)))
    else $error("reported level beyond lowest level");

  a_no_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.picked_valid) |-> (out_ch.picked_task == '0))
    else $error("picked task set without a pick");
`endif

endmodule
`default_nettype wire
